@@ rtl/clrp_pkg.sv @@
package clrp_pkg;

    localparam int LINES_DEFAULT = 8;
    localparam int QUEUE_DEPTH   = 2;

    localparam int FUNC_W = 2;
    localparam int LIDX_W = 3;
    localparam int TAG_W  = 16;
    localparam int MET_W  = 32;
    localparam int MODE_W = 2;
    localparam int VLINE_W = 3;

    localparam logic [FUNC_W-1:0] FN_HIT   = 2'd0;
    localparam logic [FUNC_W-1:0] FN_FILL  = 2'd1;
    localparam logic [FUNC_W-1:0] FN_QUERY = 2'd2;

    localparam logic [MODE_W-1:0] MODE_LRU  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LFU  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FIFO = 2'd2;

    // Work classes handed from the front end to the back end.
    typedef enum logic [2:0] {
        K_NOP,       // no state change, plain result
        K_HIT_LRU,
        K_HIT_LFU,
        K_FILL,
        K_QUERY,     // full scan over all lines
        K_QFIX       // query under a reserved mode: answers line 0
    } kind_t;

    typedef struct packed {
        kind_t               kind;
        logic [MODE_W-1:0]   mode;
        logic [LIDX_W-1:0]   line;
        logic [TAG_W-1:0]    tag;
    } op_t;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [MET_W-1:0] count;
        logic [MET_W-1:0] last;
        logic [MET_W-1:0] ins;
    } entry_t;

endpackage

@@ rtl/clrp_ram.sv @@
module clrp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/clrp_front.sv @@
module clrp_front
    import clrp_pkg::*;
#(
    parameter int LINES = LINES_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [MODE_W-1:0] cfg_data,
    input  logic [FUNC_W-1:0] func,
    input  logic [LIDX_W-1:0] line_index,
    input  logic [TAG_W-1:0]  block_tag,
    output op_t               op
);

    logic [MODE_W-1:0] mode_reg;
    logic              in_range;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_LRU;
        end
        else if (cfg_valid && cfg_ready)
        begin
            mode_reg <= cfg_data;
        end
    end

    // Lines beyond the cache size are silently ignored by hits and fills.
    assign in_range = int'(line_index) < LINES;

    always_comb
    begin
        op.mode = mode_reg;
        op.line = line_index;
        op.tag  = block_tag;
        op.kind = K_NOP;
        unique case (func)
            FN_HIT:
            begin
                if (in_range && mode_reg == MODE_LRU)
                begin
                    op.kind = K_HIT_LRU;
                end
                else if (in_range && mode_reg == MODE_LFU)
                begin
                    op.kind = K_HIT_LFU;
                end
            end
            FN_FILL:
            begin
                if (in_range)
                begin
                    op.kind = K_FILL;
                end
            end
            FN_QUERY:
            begin
                op.kind = (mode_reg == MODE_LRU || mode_reg == MODE_LFU ||
                           mode_reg == MODE_FIFO) ? K_QUERY : K_QFIX;
            end
            default:
            begin
                op.kind = K_NOP;
            end
        endcase
    end

endmodule

@@ rtl/clrp_queue.sv @@
module clrp_queue
    import clrp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH,
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  op_t  push_op,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output op_t  head_op
);

    op_t           slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push;
    logic          do_pop;

    assign full      = count_reg == CW'(DEPTH);
    assign not_empty = count_reg != '0;
    assign head_op   = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ rtl/clrp_back.sv @@
module clrp_back
    import clrp_pkg::*;
#(
    parameter int LINES = LINES_DEFAULT,
    localparam int AW = $clog2(LINES)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_not_empty,
    input  op_t                q_op,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [VLINE_W-1:0] victim_line,
    output logic               victim_valid
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RMW  = 3'b010,
        S_SCAN = 3'b100
    } state_t;

    localparam int EW = $bits(entry_t);

    state_t             state_reg, state_next;
    op_t                op_reg, op_next;
    logic [AW-1:0]      cnt_reg, cnt_next;
    logic [AW-1:0]      best_idx_reg, best_idx_next;
    logic [MET_W-1:0]   best_reg, best_next;
    logic [MET_W-1:0]   use_clk_reg, use_clk_next;
    logic [MET_W-1:0]   fifo_clk_reg, fifo_clk_next;
    logic [LINES-1:0]   valid_reg, valid_next;
    logic               vld_rd_reg;
    logic               out_valid_reg, out_valid_next;
    logic [VLINE_W-1:0] vline_reg, vline_next;
    logic               vvalid_reg, vvalid_next;

    logic               out_free;
    logic               re;
    logic [AW-1:0]      raddr;
    logic               we;
    logic [AW-1:0]      waddr;
    entry_t             wdata;
    logic [EW-1:0]      rdata;
    entry_t             cur;
    entry_t             upd;
    logic [MET_W-1:0]   metric;
    logic               take;

    clrp_ram #(
        .WIDTH (EW),
        .DEPTH (LINES)
    ) u_meta (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign out_valid    = out_valid_reg;
    assign victim_line  = vline_reg;
    assign victim_valid = vvalid_reg;
    assign out_free     = !out_valid_reg || !out_stall;

    // A line that was never written reads as all zero.
    assign cur = vld_rd_reg ? entry_t'(rdata) : '0;

    always_comb
    begin
        unique case (op_reg.mode)
            MODE_LFU:  metric = cur.count;
            MODE_FIFO: metric = cur.ins;
            default:   metric = cur.last;
        endcase
    end

    // Smaller signed metric wins; ties keep the earlier line.
    assign take = (cnt_reg == '0) || ($signed(metric) < $signed(best_reg));

    always_comb
    begin
        upd           = cur;
        use_clk_next  = use_clk_reg;
        fifo_clk_next = fifo_clk_reg;
        unique case (op_reg.kind) inside
            K_HIT_LRU:
            begin
                upd.last     = use_clk_reg + 1'b1;
                use_clk_next = use_clk_reg + 1'b1;
            end
            K_HIT_LFU:
            begin
                upd.count = cur.count + 1'b1;
            end
            K_FILL:
            begin
                if (cur.tag != op_reg.tag)
                begin
                    upd.count     = MET_W'(1);
                    upd.ins       = fifo_clk_reg;
                    fifo_clk_next = fifo_clk_reg + 1'b1;
                end
                else
                begin
                    upd.count = cur.count + 1'b1;
                end
                upd.tag      = op_reg.tag;
                upd.last     = use_clk_reg;
                use_clk_next = use_clk_reg + 1'b1;
            end
            K_NOP, K_QUERY, K_QFIX:
            begin
            end
            default:
            begin
            end
        endcase
        if (state_reg != S_RMW)
        begin
            use_clk_next  = use_clk_reg;
            fifo_clk_next = fifo_clk_reg;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        cnt_next       = cnt_reg;
        best_idx_next  = best_idx_reg;
        best_next      = best_reg;
        valid_next     = valid_reg;
        out_valid_next = out_valid_reg && out_stall;
        vline_next     = vline_reg;
        vvalid_next    = vvalid_reg;
        q_pop          = 1'b0;
        re             = 1'b0;
        raddr          = AW'(q_op.line);
        we             = 1'b0;
        waddr          = AW'(op_reg.line);
        wdata          = upd;

        unique case (state_reg)
            S_IDLE:
            begin
                // Popping only with a free output slot keeps every result
                // writable when its work finishes.
                if (q_not_empty && out_free)
                begin
                    q_pop   = 1'b1;
                    op_next = q_op;
                    unique case (q_op.kind) inside
                        K_NOP, K_QFIX:
                        begin
                            out_valid_next = 1'b1;
                            vline_next     = '0;
                            vvalid_next    = q_op.kind == K_QFIX;
                        end
                        K_HIT_LRU, K_HIT_LFU, K_FILL:
                        begin
                            re         = 1'b1;
                            raddr      = AW'(q_op.line);
                            state_next = S_RMW;
                        end
                        K_QUERY:
                        begin
                            re         = 1'b1;
                            raddr      = '0;
                            cnt_next   = '0;
                            state_next = S_SCAN;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_RMW:
            begin
                we                = 1'b1;
                valid_next[waddr] = 1'b1;
                out_valid_next    = 1'b1;
                vline_next        = '0;
                vvalid_next       = 1'b0;
                state_next        = S_IDLE;
            end
            S_SCAN:
            begin
                if (take)
                begin
                    best_next     = metric;
                    best_idx_next = cnt_reg;
                end
                if (cnt_reg == AW'(LINES - 1))
                begin
                    out_valid_next = 1'b1;
                    vline_next     = VLINE_W'(take ? cnt_reg : best_idx_reg);
                    vvalid_next    = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    re       = 1'b1;
                    raddr    = cnt_reg + 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        cnt_reg      <= cnt_next;
        best_idx_reg <= best_idx_next;
        best_reg     <= best_next;
        vline_reg    <= vline_next;
        vvalid_reg   <= vvalid_next;
        if (re)
        begin
            vld_rd_reg <= valid_reg[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            use_clk_reg   <= MET_W'(1);
            fifo_clk_reg  <= MET_W'(1);
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            use_clk_reg   <= use_clk_next;
            fifo_clk_reg  <= fifo_clk_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ rtl/cache_line_replacement_policy.sv @@
// Replacement bookkeeping for a fully associative cache of LINES lines. Each word
// on the input channel is a hit, a fill or a victim query, and each gives exactly
// one result word; only a query result has victim_valid set. Words are classified
// on entry and wait in a two-entry queue while the back end works through them
// against a single metadata RAM with one registered read port: a fill, or a hit
// under LRU or LFU, takes a read and a write, a query reads every line in turn,
// and any other word needs no RAM access. A new word is started only when the
// output register is free. The policy register is written through the
// configuration channel, which is always ready.
module cache_line_replacement_policy
    import clrp_pkg::*;
#(
    parameter int LINES = LINES_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [MODE_W-1:0]  cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [FUNC_W-1:0]  func,
    input  logic [LIDX_W-1:0]  line_index,
    input  logic [TAG_W-1:0]   block_tag,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [VLINE_W-1:0] victim_line,
    output logic               victim_valid
);

    op_t  front_op;
    op_t  head_op;
    logic q_full;
    logic q_not_empty;
    logic q_pop;

    clrp_front #(
        .LINES (LINES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .func       (func),
        .line_index (line_index),
        .block_tag  (block_tag),
        .op         (front_op)
    );

    clrp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid),
        .push_op   (front_op),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_op   (head_op)
    );

    assign in_stall = q_full;

    clrp_back #(
        .LINES (LINES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_not_empty  (q_not_empty),
        .q_op         (head_op),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .victim_line  (victim_line),
        .victim_valid (victim_valid)
    );

endmodule

@@ rtl/clrp_checker.sv @@
module clrp_checker
    import clrp_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               cfg_valid,
    input logic               cfg_ready,
    input logic [MODE_W-1:0]  cfg_data,
    input logic               in_valid,
    input logic               in_stall,
    input logic [FUNC_W-1:0]  func,
    input logic [LIDX_W-1:0]  line_index,
    input logic [TAG_W-1:0]   block_tag,
    input logic               out_valid,
    input logic               out_stall,
    input logic [VLINE_W-1:0] victim_line,
    input logic               victim_valid
);

    // A result word that is held back keeps its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(victim_line) && $stable(victim_valid))
        else $error("result word changed while stalled");

    // Results that do not answer a query carry line zero.
    a_nonquery_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !victim_valid |-> victim_line == '0)
        else $error("non-query result with nonzero line");

    // The policy register never holds off a write.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration channel not ready");

    // No result word is shown right out of reset.
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result word present after reset");

endmodule

bind cache_line_replacement_policy clrp_checker u_clrp_checker (.*);
